/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge, reset included.
`define AST_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checks a property at every rising edge outside reset.
`define AST_ACTIVE(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* src/crm_pkg.sv */
// Types, widths and helpers shared by the Cayley to rotation matrix unit.
`default_nettype none
package crm_pkg;

  localparam int ELEM_W    = 32;
  localparam int FIN       = ELEM_W / 2;
  localparam int FOUT      = ELEM_W - 2;
  localparam int PW        = 2 * ELEM_W;
  localparam int NW        = 2 * ELEM_W + 3;
  localparam int DW        = 2 * ELEM_W + 1;
  localparam int NENT      = 9;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] cayley_x;
    logic signed [ELEM_W-1:0] cayley_y;
    logic signed [ELEM_W-1:0] cayley_z;
  } crm_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] rot_00;
    logic signed [ELEM_W-1:0] rot_01;
    logic signed [ELEM_W-1:0] rot_02;
    logic signed [ELEM_W-1:0] rot_10;
    logic signed [ELEM_W-1:0] rot_11;
    logic signed [ELEM_W-1:0] rot_12;
    logic signed [ELEM_W-1:0] rot_20;
    logic signed [ELEM_W-1:0] rot_21;
    logic signed [ELEM_W-1:0] rot_22;
  } crm_out_t;

  typedef struct packed {
    logic [NENT-1:0][NW-1:0] num;
    logic [DW-1:0]           den;
  } crm_mid_t;

  function automatic logic signed [PW-1:0] smul(logic signed [ELEM_W-1:0] a,
                                                logic signed [ELEM_W-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic signed [NW-1:0] ext_p(logic signed [PW-1:0] v);
    return {{(NW-PW){v[PW-1]}}, v};
  endfunction

  function automatic logic signed [NW-1:0] ext_e(logic signed [ELEM_W-1:0] v);
    return {{(NW-ELEM_W){v[ELEM_W-1]}}, v};
  endfunction

endpackage
`default_nettype wire

/* src/crm_fifo.sv */
// Small first-in first-out queue built from registers.
`default_nettype none
module crm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule
`default_nettype wire

/* src/crm_front.sv */
// Front pipeline: products of the Cayley components, then the numerators and the norm.
`default_nettype none
module crm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire crm_pkg::crm_in_t  in_data,
  output logic                   mid_push,
  input  wire logic              mid_full,
  output crm_pkg::crm_mid_t      mid_data
);
  localparam int W  = crm_pkg::ELEM_W;
  localparam int PW = crm_pkg::PW;
  localparam int NW = crm_pkg::NW;
  localparam int DW = crm_pkg::DW;

  logic                 en;
  logic                 a_v_r, b_v_r;
  logic signed [W-1:0]  x_r, y_r, z_r;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r;
  logic signed [NW-1:0] one, xs, ys, zs, exx, eyy, ezz, exy, exz, eyz, d_s;
  logic [crm_pkg::NENT-1:0][NW-1:0] num_nxt;
  crm_pkg::crm_mid_t    mid_r;

  assign en       = !(b_v_r && mid_full);
  assign in_full  = !en;
  assign mid_push = b_v_r && !mid_full;
  assign mid_data = mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_push;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= in_data.cayley_x;
      y_r  <= in_data.cayley_y;
      z_r  <= in_data.cayley_z;
      xx_r <= crm_pkg::smul(in_data.cayley_x, in_data.cayley_x);
      yy_r <= crm_pkg::smul(in_data.cayley_y, in_data.cayley_y);
      zz_r <= crm_pkg::smul(in_data.cayley_z, in_data.cayley_z);
      xy_r <= crm_pkg::smul(in_data.cayley_x, in_data.cayley_y);
      xz_r <= crm_pkg::smul(in_data.cayley_x, in_data.cayley_z);
      yz_r <= crm_pkg::smul(in_data.cayley_y, in_data.cayley_z);
      mid_r.num <= num_nxt;
      mid_r.den <= d_s[DW-1:0];
    end
  end

  always_comb begin
    one = NW'(1) <<< (2 * crm_pkg::FIN);
    xs  = crm_pkg::ext_e(x_r) <<< crm_pkg::FIN;
    ys  = crm_pkg::ext_e(y_r) <<< crm_pkg::FIN;
    zs  = crm_pkg::ext_e(z_r) <<< crm_pkg::FIN;
    exx = crm_pkg::ext_p(xx_r);
    eyy = crm_pkg::ext_p(yy_r);
    ezz = crm_pkg::ext_p(zz_r);
    exy = crm_pkg::ext_p(xy_r);
    exz = crm_pkg::ext_p(xz_r);
    eyz = crm_pkg::ext_p(yz_r);
    d_s = one + exx + eyy + ezz;
    num_nxt[0] = one + exx - eyy - ezz;
    num_nxt[1] = (exy - zs) <<< 1;
    num_nxt[2] = (exz + ys) <<< 1;
    num_nxt[3] = (exy + zs) <<< 1;
    num_nxt[4] = one + eyy - exx - ezz;
    num_nxt[5] = (eyz - xs) <<< 1;
    num_nxt[6] = (exz - ys) <<< 1;
    num_nxt[7] = (eyz + xs) <<< 1;
    num_nxt[8] = one + ezz - exx - eyy;
  end
endmodule
`default_nettype wire

/* src/crm_back.sv */
// Back pipeline: nine restoring dividers, one quotient bit per stage, then rounding.
`default_nettype none
module crm_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              mid_empty,
  output logic                   mid_pop,
  input  wire crm_pkg::crm_mid_t mid_data,
  output logic                   out_push,
  input  wire logic              out_full,
  output crm_pkg::crm_out_t      out_data
);
  localparam int W  = crm_pkg::ELEM_W;
  localparam int NW = crm_pkg::NW;
  localparam int DW = crm_pkg::DW;
  localparam int NE = crm_pkg::NENT;
  localparam int S  = crm_pkg::FOUT + 1;

  logic          en;
  logic          v_r   [S];
  logic [NW-1:0] r_r   [S][NE];
  logic [W-1:0]  q_r   [S][NE];
  logic          neg_r [S][NE];
  logic [DW-1:0] d_r   [S];

  logic [NW-1:0] r0 [NE];
  logic          q0 [NE];
  logic [NE-1:0][W-1:0] res;

  assign en       = !(v_r[S-1] && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = v_r[S-1] && !out_full;
  assign out_data = crm_pkg::crm_out_t'(res);

  always_comb begin
    logic [NW-1:0] mag;
    logic [NW-1:0] dx;
    dx = NW'(mid_data.den);
    for (int k = 0; k < NE; k++) begin
      mag   = mid_data.num[k][NW-1] ? (~mid_data.num[k] + 1'b1) : mid_data.num[k];
      q0[k] = (mag >= dx);
      r0[k] = q0[k] ? (mag - dx) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= !mid_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= mid_data.den;
      for (int k = 0; k < NE; k++) begin
        r_r[0][k]   <= r0[k];
        q_r[0][k]   <= W'(q0[k]);
        neg_r[0][k] <= mid_data.num[k][NW-1];
      end
    end
  end

  for (genvar s = 1; s < S; s++) begin : g_stage
    logic [NW-1:0] rn [NE];
    logic [W-1:0]  qn [NE];

    always_comb begin
      logic [NW-1:0] sh;
      logic          ge;
      for (int k = 0; k < NE; k++) begin
        sh    = r_r[s-1][k] << 1;
        ge    = (sh >= NW'(d_r[s-1]));
        rn[k] = ge ? (sh - NW'(d_r[s-1])) : sh;
        qn[k] = {q_r[s-1][k][W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s] <= d_r[s-1];
        for (int k = 0; k < NE; k++) begin
          r_r[s][k]   <= rn[k];
          q_r[s][k]   <= qn[k];
          neg_r[s][k] <= neg_r[s-1][k];
        end
      end
    end
  end

  always_comb begin
    logic [NW-1:0] sh;
    logic [W:0]    qe;
    logic [W:0]    lim;
    for (int k = 0; k < NE; k++) begin
      sh  = r_r[S-1][k] << 1;
      qe  = {1'b0, q_r[S-1][k]} + (W+1)'(sh >= NW'(d_r[S-1]));
      lim = (W+1)'(1) << (W - 1);
      if (!neg_r[S-1][k] && qe > lim - 1'b1) begin
        qe = lim - 1'b1;
      end
      if (neg_r[S-1][k] && qe > lim) begin
        qe = lim;
      end
      res[NE-1-k] = neg_r[S-1][k] ? (~qe[W-1:0] + 1'b1) : qe[W-1:0];
    end
  end
endmodule
`default_nettype wire

/* src/cayley_to_rotation_matrix_unit.sv */
// Top level of the Cayley vector to rotation matrix unit.
`default_nettype none
// Takes one Cayley vector (x, y, z) in signed Q16.16 per cycle while in_full is low and
// returns the nine entries of the matching rotation matrix, row major, in signed Q2.30,
// rounded to nearest with ties away from zero. The throughput is one request per cycle
// while in_full is low. The front pipeline registers the products and then the sums, the
// middle queue holds them, and in the back pipeline each stage resolves one quotient bit of
// nine parallel restoring dividers; the result then waits in the output queue until popped.
module cayley_to_rotation_matrix_unit #(
  parameter int MID_DEPTH = crm_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = crm_pkg::OUT_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire crm_pkg::crm_in_t  in_data,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output crm_pkg::crm_out_t      out_data
);
  localparam int MW = $bits(crm_pkg::crm_mid_t);
  localparam int OW = $bits(crm_pkg::crm_out_t);

  logic              mid_push, mid_full, mid_pop, mid_empty;
  crm_pkg::crm_mid_t mid_wr;
  logic [MW-1:0]     mid_rd;
  logic              res_push, res_full;
  crm_pkg::crm_out_t res_wr;
  logic [OW-1:0]     res_rd;

  crm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .mid_push (mid_push),
    .mid_full (mid_full),
    .mid_data (mid_wr)
  );

  crm_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  crm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_data  (crm_pkg::crm_mid_t'(mid_rd)),
    .out_push  (res_push),
    .out_full  (res_full),
    .out_data  (res_wr)
  );

  crm_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_rd),
    .empty   (out_empty)
  );

  assign out_data = crm_pkg::crm_out_t'(res_rd);
endmodule
`default_nettype wire

/* src/crm_checker.sv */
// Port checker for the Cayley to rotation matrix unit and its bind.
`default_nettype none
`include "assert_macros.svh"
module crm_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_push,
  input wire logic              in_full,
  input wire logic              out_empty,
  input wire logic              out_pop,
  input wire crm_pkg::crm_out_t out_data
);
  `AST_ALWAYS(a_rst_empty, clk, !rst_n |=> out_empty, "Result queue not empty after reset.")
  `AST_ALWAYS(a_rst_ready, clk, !rst_n |=> !in_full, "Input not ready after reset.")
  `AST_ACTIVE(a_no_result_early, clk, rst_n, $past(!rst_n) |=> out_empty, "Result appeared too soon after reset.")
  `AST_ACTIVE(a_hold, clk, rst_n, (!out_empty && !out_pop) |=> $stable(out_data) && !out_empty, "Waiting result changed.")
endmodule

bind cayley_to_rotation_matrix_unit crm_checker u_crm_checker (.*);
`default_nettype wire
